// File: src/sli_pkg.sv
// Shared types and constants for the sorted list insert/delete block.
`timescale 1ns / 1ps
`default_nettype none
package sli_pkg;

  // Fixed field widths of the channels
  localparam int VALUE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int VALUE_TOP = (1 << VALUE_W) - 1;

  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Result status codes
  localparam status_t STS_DONE      = 2'd0;
  localparam status_t STS_FULL      = 2'd1;
  localparam status_t STS_NOT_FOUND = 2'd2;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // update the list and the result register
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: src/sli_in_if.sv
// Input channel: operation and value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface sli_in_if;
  logic            valid;
  logic            ready;
  sli_pkg::op_t    op;
  sli_pkg::value_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

// File: src/sli_out_if.sv
// Result channel: status, count and smallest value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface sli_out_if;
  logic             valid;
  logic             ready;
  sli_pkg::status_t status;
  sli_pkg::count_t  count;
  sli_pkg::value_t  smallest;

  modport source (output valid, output status, output count, output smallest, input ready);
  modport sink   (input valid, input status, input count, input smallest, output ready);
endinterface
`default_nettype wire

// File: src/sli_ctrl.sv
// Controller: sequences capture, list update and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module sli_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sli_pkg::dp_cmd_t      cmd
);
  import sli_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    // new word only when the result register is empty or drains this cycle
    in_ready      = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/sli_dpath.sv
// Datapath: row of compare-and-shift cells, fill counter and result register.
`timescale 1ns / 1ps
`default_nettype none
module sli_dpath #(
  parameter int DEPTH     = 16,
  parameter int VALUE_MAX = 255
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sli_pkg::dp_cmd_t  cmd,
  input  wire sli_pkg::op_t      in_op,
  input  wire sli_pkg::value_t   in_value,
  output sli_pkg::status_t       out_status,
  output sli_pkg::count_t        out_count,
  output sli_pkg::value_t        out_smallest
);
  import sli_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int VCLIP  = (VALUE_MAX > VALUE_TOP) ? VALUE_TOP : VALUE_MAX;
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(DEPTH);

  op_t               op_r;
  value_t            val_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  value_t            e_r   [DEPTH];
  value_t            e_nxt [DEPTH];
  status_t           status_r, status_nxt;
  count_t            count_r;
  value_t            smallest_r, smallest_nxt;

  logic [DEPTH-1:0] lt;     // stored entry below the value
  logic [DEPTH-1:0] first;  // first cell not holding a live entry below the value
  logic [DEPTH-1:0] hit;    // that cell is live and equal
  logic             full, found, do_ins, do_del;

  // Per-cell compare and next value
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [FILL_W-1:0] IDX = FILL_W'(g);
    logic live;
    assign live = IDX < fill_r;
    assign lt[g] = live && (e_r[g] < val_r);
    if (g == 0) begin : g_head
      assign first[g] = !lt[g];
    end else begin : g_body
      assign first[g] = !lt[g] && lt[g-1];
    end
    assign hit[g] = first[g] && live && (e_r[g] == val_r);

    always_comb begin
      e_nxt[g] = e_r[g];
      if (do_ins && !lt[g]) begin
        if (first[g]) begin
          e_nxt[g] = val_r;
        end else begin
          e_nxt[g] = e_r[(g == 0) ? 0 : g - 1];
        end
      end else if (do_del && !lt[g] && (g < DEPTH - 1)) begin
        e_nxt[g] = e_r[(g < DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  assign full   = (fill_r == FULL_CNT);
  assign found  = |hit;
  assign do_ins = (op_r == OP_INSERT) && !full;
  assign do_del = (op_r == OP_DELETE) && found;

  // Status and fill update
  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = STS_DONE;
    priority if (op_r == OP_INSERT) begin
      if (full) begin
        status_nxt = STS_FULL;
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end else begin
      if (found) begin
        fill_nxt = fill_r - FILL_W'(1);
      end else begin
        status_nxt = STS_NOT_FOUND;
      end
    end
    smallest_nxt = (fill_nxt != '0) ? e_nxt[0] : '0;
  end

  // Fill counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.exec) begin
      fill_r <= fill_nxt;
    end
  end

  // Captured word, saturated to the value limit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      val_r <= (in_value > value_t'(VCLIP)) ? value_t'(VCLIP) : in_value;
    end
  end

  // List cells and result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        e_r[i] <= e_nxt[i];
      end
      status_r   <= status_nxt;
      count_r    <= COUNT_W'(fill_nxt);
      smallest_r <= smallest_nxt;
    end
  end

  assign out_status   = status_r;
  assign out_count    = count_r;
  assign out_smallest = smallest_r;

endmodule
`default_nettype wire

// File: src/sorted_list_insert_delete.sv
// Top level of the bounded sorted list with insert and delete.
//
//   channel | dir | fields                    | handshake
//   in_ch   | in  | op, value                 | valid/ready
//   out_ch  | out | status, count, smallest   | valid/ready
//
// Each word is first captured, then all cells compare against the value and
// shift in parallel. The next word is taken once the result register is empty
// or is being read in that cycle.
// Reset (rst_n low, synchronous) empties the list; cell contents are not
// cleared. A stall on out_ch holds the result and blocks further input.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_insert_delete #(
  parameter int DEPTH     = 16,
  parameter int VALUE_MAX = 255
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sli_in_if.sink    in_ch,
  sli_out_if.source out_ch
);
  import sli_pkg::*;

  dp_cmd_t cmd;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sli_dpath #(
    .DEPTH     (DEPTH),
    .VALUE_MAX (VALUE_MAX)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_ch.op),
    .in_value     (in_ch.value),
    .out_status   (out_ch.status),
    .out_count    (out_ch.count),
    .out_smallest (out_ch.smallest)
  );

endmodule
`default_nettype wire
